@@ rtl/core/bfeu_pkg.sv @@
package bfeu_pkg;

  // Field widths of the channels
  localparam int ACT_W  = 4;
  localparam int ARG_W  = 16;
  localparam int PC_W   = 12;
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 15;
  localparam int STEP_W = ARG_W + 1;

  // Default tape address width (32768 cells)
  localparam int TAPE_AW_DEF = 15;

  // Incoming action codes
  localparam logic [ACT_W-1:0] ACT_END     = 4'd0;
  localparam logic [ACT_W-1:0] ACT_PTR_INC = 4'd1;
  localparam logic [ACT_W-1:0] ACT_PTR_DEC = 4'd2;
  localparam logic [ACT_W-1:0] ACT_VAL_INC = 4'd3;
  localparam logic [ACT_W-1:0] ACT_VAL_DEC = 4'd4;
  localparam logic [ACT_W-1:0] ACT_PUT     = 4'd5;
  localparam logic [ACT_W-1:0] ACT_GET     = 4'd6;
  localparam logic [ACT_W-1:0] ACT_JZ      = 4'd7;
  localparam logic [ACT_W-1:0] ACT_JNZ     = 4'd8;
  localparam logic [ACT_W-1:0] ACT_ZERO    = 4'd9;
  localparam logic [ACT_W-1:0] ACT_SCAN    = 4'd10;
  localparam logic [ACT_W-1:0] ACT_MOVEADD = 4'd11;

  // Decoded operation kinds handed from front to back
  localparam int KIND_W = 4;
  localparam logic [KIND_W-1:0] K_NOP      = 4'd0;
  localparam logic [KIND_W-1:0] K_END      = 4'd1;
  localparam logic [KIND_W-1:0] K_PTR      = 4'd2;
  localparam logic [KIND_W-1:0] K_CELL_ADD = 4'd3;
  localparam logic [KIND_W-1:0] K_PUT      = 4'd4;
  localparam logic [KIND_W-1:0] K_STORE    = 4'd5;
  localparam logic [KIND_W-1:0] K_JZ       = 4'd6;
  localparam logic [KIND_W-1:0] K_JNZ      = 4'd7;
  localparam logic [KIND_W-1:0] K_SCAN     = 4'd8;
  localparam logic [KIND_W-1:0] K_MOVEADD  = 4'd9;

  // Decoded operation
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [STEP_W-1:0] step;       // signed pointer delta / stride / offset
    logic [BYTE_W-1:0] byte_val;   // addend or byte to store
    logic [CNT_W-1:0]  put_count;
    logic [PC_W-1:0]   seq_pc;     // pc when no jump is taken
    logic [PC_W-1:0]   jump_pc;    // pc when a jump is taken
  } bfeu_op_t;

  localparam int QUEUE_DEPTH = 2;

endpackage

@@ rtl/core/bfeu_if.sv @@
// Instruction channel
interface bfeu_in_if import bfeu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic signed [ARG_W-1:0] argument;
  logic [PC_W-1:0]   current_pc;
  logic [BYTE_W-1:0] read_byte;

  modport source (output valid, action, argument, current_pc, read_byte, input ready);
  modport sink   (input valid, action, argument, current_pc, read_byte, output ready);
endinterface

// Result channel
interface bfeu_out_if import bfeu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PC_W-1:0]   next_pc;
  logic [BYTE_W-1:0] out_byte;
  logic [CNT_W-1:0]  out_count;
  logic              halted;

  modport source (output valid, next_pc, out_byte, out_count, halted, input ready);
  modport sink   (input valid, next_pc, out_byte, out_count, halted, output ready);
endinterface

@@ rtl/core/brainfuck_execute_unit.sv @@
// Channel   Dir  Handshake     Payload
// in_ch     in   valid/ready   action, argument, current_pc, read_byte
// out_ch    out  valid/ready   next_pc, out_byte, out_count, halted
//
// After reset the tape is zeroed one cell per cycle; in_ch.ready stays low until
// every cell is cleared.
// Back end: pointer moves, get, zero, end and no-ops finish from idle; cell add, put
// and jumps read the cell first; a scan reads a cell per stride to a zero or a full
// lap; a move-add reads its source, stops if it is zero, else adds it into the target
// and clears the source, all through the single tape RAM port (one access per cycle).
// A two-entry queue lets the front take beats while the back works or out_ch stalls.
module brainfuck_execute_unit import bfeu_pkg::*; #(
  parameter int TAPE_AW = TAPE_AW_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  bfeu_in_if.sink     in_ch,
  bfeu_out_if.source  out_ch
);

  logic     tape_ready;
  logic     q_full;
  logic     push;
  bfeu_op_t push_op;
  logic     q_valid;
  logic     q_pop;
  bfeu_op_t q_head;

  bfeu_front u_front (
    .in_ch      (in_ch),
    .tape_ready (tape_ready),
    .q_full     (q_full),
    .push       (push),
    .push_op    (push_op)
  );

  bfeu_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_op    (push_op),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_op    (q_head)
  );

  bfeu_back #(
    .TAPE_AW (TAPE_AW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .tape_ready (tape_ready),
    .out_ch     (out_ch)
  );

  // Once cleared, the tape stays usable until the next reset
  a_ready_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    tape_ready |=> tape_ready)
    else $error("tape clear restarted without reset");

  // The back end never pops an empty queue
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

  // No beat goes in or out while the tape is being cleared
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !tape_ready |-> (!push && !out_ch.valid))
    else $error("traffic during tape clear");

endmodule

@@ rtl/core/bfeu_ram.sv @@
module bfeu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read; read data holds while re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

@@ rtl/core/bfeu_queue.sv @@
module bfeu_queue import bfeu_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  bfeu_op_t push_op,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output bfeu_op_t head_op
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  bfeu_op_t         entry_r [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]      count_r, count_nxt;

  assign full       = (count_r == (PW+1)'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_op    = entry_r[rd_ptr_r];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + (PW+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

@@ rtl/core/bfeu_front.sv @@
module bfeu_front import bfeu_pkg::*; (
  bfeu_in_if.sink  in_ch,
  input  logic     tape_ready,
  input  logic     q_full,
  output logic     push,
  output bfeu_op_t push_op
);

  logic              arg_pos;
  logic [STEP_W-1:0] arg_ext;

  // Take a beat whenever the queue has room and the tape is cleared
  assign in_ch.ready = tape_ready && !q_full;
  assign push        = in_ch.valid && in_ch.ready;

  assign arg_pos = !in_ch.argument[ARG_W-1] && (in_ch.argument != '0);
  assign arg_ext = {in_ch.argument[ARG_W-1], in_ch.argument};

  // Classify the action and precompute everything that needs no tape data
  always_comb begin
    push_op.kind      = K_NOP;
    push_op.step      = arg_ext;
    push_op.byte_val  = in_ch.argument[BYTE_W-1:0];
    push_op.put_count = '0;
    push_op.seq_pc    = in_ch.current_pc + PC_W'(1);
    push_op.jump_pc   = in_ch.argument[PC_W-1:0] + PC_W'(1);
    case (in_ch.action)
      ACT_END: begin
        push_op.kind   = K_END;
        push_op.seq_pc = in_ch.current_pc;
      end
      ACT_PTR_INC: push_op.kind = K_PTR;
      ACT_PTR_DEC: begin
        push_op.kind = K_PTR;
        push_op.step = ~arg_ext + STEP_W'(1);
      end
      ACT_VAL_INC: push_op.kind = K_CELL_ADD;
      ACT_VAL_DEC: begin
        push_op.kind     = K_CELL_ADD;
        push_op.byte_val = ~in_ch.argument[BYTE_W-1:0] + BYTE_W'(1);
      end
      ACT_PUT: begin
        push_op.kind      = K_PUT;
        push_op.put_count = arg_pos ? in_ch.argument[CNT_W-1:0] : '0;
      end
      ACT_GET: begin
        // non-positive count leaves the cell alone
        push_op.kind     = arg_pos ? K_STORE : K_NOP;
        push_op.byte_val = in_ch.read_byte;
      end
      ACT_JZ:      push_op.kind = K_JZ;
      ACT_JNZ:     push_op.kind = K_JNZ;
      ACT_ZERO: begin
        push_op.kind     = K_STORE;
        push_op.byte_val = '0;
      end
      ACT_SCAN:    push_op.kind = K_SCAN;
      ACT_MOVEADD: push_op.kind = K_MOVEADD;
      default:     push_op.kind = K_NOP;
    endcase
  end

endmodule

@@ rtl/core/bfeu_back.sv @@
module bfeu_back import bfeu_pkg::*; #(
  parameter int TAPE_AW = TAPE_AW_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  bfeu_op_t  q_head,
  output logic      q_pop,
  output logic      tape_ready,
  bfeu_out_if.source out_ch
);

  localparam int TAPE_SIZE = 1 << TAPE_AW;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_MADD  = 3'd3;
  localparam logic [2:0] ST_MZERO = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [TAPE_AW-1:0] clr_addr_r, clr_addr_nxt;
  logic [TAPE_AW-1:0] dp_r, dp_nxt;
  logic [TAPE_AW:0]   strides_r, strides_nxt;
  bfeu_op_t           op_r, op_nxt;
  logic [BYTE_W-1:0]  src_r, src_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [PC_W-1:0]    next_pc_r;
  logic [BYTE_W-1:0]  out_byte_r;
  logic [CNT_W-1:0]   out_count_r;
  logic               halted_r;

  logic               ram_we, ram_re;
  logic [TAPE_AW-1:0] ram_addr;
  logic [BYTE_W-1:0]  ram_wdata, ram_rdata;

  logic               out_free;
  logic               emit, taken;
  bfeu_op_t           res_op;
  logic [31:0]        head_step32, cur_step32;
  logic [TAPE_AW-1:0] head_step, cur_step;
  logic               cell_zero;

  bfeu_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (TAPE_SIZE)
  ) u_tape (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Sign-extend the 17-bit step, then wrap to the tape size
  assign head_step32 = {{(32-STEP_W){q_head.step[STEP_W-1]}}, q_head.step};
  assign cur_step32  = {{(32-STEP_W){op_r.step[STEP_W-1]}}, op_r.step};
  assign head_step   = head_step32[TAPE_AW-1:0];
  assign cur_step    = cur_step32[TAPE_AW-1:0];

  assign cell_zero  = (ram_rdata == '0);
  assign out_free   = !out_valid_r || out_ch.ready;
  assign tape_ready = (state_r != ST_CLEAR);

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    dp_nxt       = dp_r;
    strides_nxt  = strides_r;
    op_nxt       = op_r;
    src_nxt      = src_r;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_addr     = dp_r;
    ram_wdata    = '0;
    q_pop        = 1'b0;
    emit         = 1'b0;
    taken        = 1'b0;
    res_op       = op_r;
    case (state_r)
      ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_addr     = clr_addr_r;
        clr_addr_nxt = clr_addr_r + TAPE_AW'(1);
        if (clr_addr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        res_op = q_head;
        // start only with the result slot free so the end beat never stalls
        if (q_valid && out_free) begin
          q_pop       = 1'b1;
          op_nxt      = q_head;
          strides_nxt = '0;
          if (q_head.kind inside {K_CELL_ADD, K_PUT, K_JZ, K_JNZ, K_SCAN, K_MOVEADD}) begin
            ram_re    = 1'b1;
            state_nxt = ST_READ;
          end else begin
            emit = 1'b1;
            if (q_head.kind == K_PTR) begin
              dp_nxt = dp_r + head_step;
            end
            if (q_head.kind == K_STORE) begin
              ram_we    = 1'b1;
              ram_wdata = q_head.byte_val;
            end
          end
        end
      end
      ST_READ: begin
        case (op_r.kind)
          K_CELL_ADD: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata + op_r.byte_val;
            emit      = 1'b1;
            state_nxt = ST_IDLE;
          end
          K_JZ: begin
            taken     = cell_zero;
            emit      = 1'b1;
            state_nxt = ST_IDLE;
          end
          K_JNZ: begin
            taken     = !cell_zero;
            emit      = 1'b1;
            state_nxt = ST_IDLE;
          end
          K_SCAN: begin
            // a full lap of strides returns to the start cell
            if (cell_zero || strides_r[TAPE_AW]) begin
              emit      = 1'b1;
              state_nxt = ST_IDLE;
            end else begin
              dp_nxt      = dp_r + cur_step;
              strides_nxt = strides_r + (TAPE_AW+1)'(1);
              ram_re      = 1'b1;
              ram_addr    = dp_r + cur_step;
            end
          end
          K_MOVEADD: begin
            if (cell_zero) begin
              emit      = 1'b1;
              state_nxt = ST_IDLE;
            end else begin
              src_nxt   = ram_rdata;
              ram_re    = 1'b1;
              ram_addr  = dp_r + cur_step;
              state_nxt = ST_MADD;
            end
          end
          default: begin
            emit      = 1'b1;
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_MADD: begin
        // target first, then clear the source: a zero offset ends at zero
        ram_we    = 1'b1;
        ram_addr  = dp_r + cur_step;
        ram_wdata = ram_rdata + src_r;
        state_nxt = ST_MZERO;
      end
      ST_MZERO: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        emit      = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = emit ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      dp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      dp_r        <= dp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and result payload registers
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    src_r     <= src_nxt;
    strides_r <= strides_nxt;
    if (emit) begin
      next_pc_r   <= taken ? res_op.jump_pc : res_op.seq_pc;
      out_byte_r  <= (res_op.kind == K_PUT) ? ram_rdata : '0;
      out_count_r <= (res_op.kind == K_PUT) ? res_op.put_count : '0;
      halted_r    <= (res_op.kind == K_END);
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.next_pc   = next_pc_r;
  assign out_ch.out_byte  = out_byte_r;
  assign out_ch.out_count = out_count_r;
  assign out_ch.halted    = halted_r;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import bfeu_pkg::*;

  localparam int TAPE_CELLS     = 1 << TAPE_AW_DEF;
  localparam int N_RANDOM       = 1000;
  localparam int LONG_SCAN      = 64;   // strides beyond which a scan counts as long
  localparam int MAX_LONG_SCANS = 4;
  localparam int MAX_REPORTS    = 10;

  // Codes the block treats as no-ops
  localparam logic [ACT_W-1:0] ACT_UNUSED_LO = 4'd12;
  localparam logic [ACT_W-1:0] ACT_UNUSED_HI = 4'd15;

  typedef struct {
    logic [PC_W-1:0]   next_pc;
    logic [BYTE_W-1:0] out_byte;
    logic [CNT_W-1:0]  out_count;
    logic              halted;
  } exec_result_t;

  // Tape/pointer shadow plus the queue of results still owed by the block
  class bfeu_scoreboard;
    logic [BYTE_W-1:0] tape [TAPE_CELLS];
    int unsigned       dptr;
    exec_result_t      owed_results [$];
    int unsigned       executed, checked, errors, halts;

    function new();
      foreach (tape[i]) tape[i] = '0;
      dptr     = 0;
      executed = 0;
      checked  = 0;
      errors   = 0;
      halts    = 0;
    endfunction

    // power-of-two tape: masking handles negative deltas too
    function int unsigned wrap_cell(int unsigned p, int delta);
      return (p + delta) & (TAPE_CELLS - 1);
    endfunction

    // strides a scan takes from the current pointer, capped at one lap
    function int unsigned scan_length(int stride);
      int unsigned p;
      int unsigned n;
      p = dptr;
      n = 0;
      while (n < TAPE_CELLS && tape[p] != 0) begin
        p = wrap_cell(p, stride);
        n++;
      end
      return n;
    endfunction

    // execute one accepted instruction beat and queue the result it owes
    function void note_instr(logic [ACT_W-1:0] action, logic signed [ARG_W-1:0] arg,
                             logic [PC_W-1:0] pc, logic [BYTE_W-1:0] rbyte);
      exec_result_t      res;
      int                a;
      logic [BYTE_W-1:0] cur_byte;
      int unsigned       tgt;
      a             = arg;
      cur_byte      = tape[dptr];
      res.next_pc   = PC_W'(pc + 1'b1);
      res.out_byte  = '0;
      res.out_count = '0;
      res.halted    = 1'b0;
      case (action)
        ACT_END: begin
          res.next_pc = pc;
          res.halted  = 1'b1;
          halts++;
        end
        ACT_PTR_INC: dptr = wrap_cell(dptr, a);
        ACT_PTR_DEC: dptr = wrap_cell(dptr, -a);
        ACT_VAL_INC: tape[dptr] = cur_byte + arg[BYTE_W-1:0];
        ACT_VAL_DEC: tape[dptr] = cur_byte - arg[BYTE_W-1:0];
        ACT_PUT: begin
          res.out_byte  = cur_byte;
          res.out_count = (a > 0) ? CNT_W'(a) : '0;
        end
        ACT_GET: if (a > 0) tape[dptr] = rbyte;
        ACT_JZ:  if (cur_byte == 0) res.next_pc = PC_W'(arg[PC_W-1:0] + 1'b1);
        ACT_JNZ: if (cur_byte != 0) res.next_pc = PC_W'(arg[PC_W-1:0] + 1'b1);
        ACT_ZERO: tape[dptr] = '0;
        ACT_SCAN: dptr = wrap_cell(dptr, a * int'(scan_length(a)));
        ACT_MOVEADD: begin
          // same-cell offset doubles then clears, so the cell ends at zero
          if (cur_byte != 0) begin
            tgt       = wrap_cell(dptr, a);
            tape[tgt] = tape[tgt] + cur_byte;
            tape[dptr] = '0;
          end
        end
        default: ;
      endcase
      owed_results.insert(owed_results.size(), res);
      executed++;
    endfunction

    // compare one result beat against the oldest owed result
    function void check_result(exec_result_t got);
      exec_result_t exp;
      if (owed_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("ERROR: unexpected result pc=%0h byte=%0h count=%0d halt=%0b",
                   got.next_pc, got.out_byte, got.out_count, got.halted);
        return;
      end
      exp = owed_results.pop_front();
      checked++;
      if (got.next_pc !== exp.next_pc || got.out_byte !== exp.out_byte ||
          got.out_count !== exp.out_count || got.halted !== exp.halted) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("ERROR: result %0d exp pc/byte/count/halt=%0h/%0h/%0d/%0b, got %0h/%0h/%0d/%0b",
                   checked, exp.next_pc, exp.out_byte, exp.out_count, exp.halted,
                   got.next_pc, got.out_byte, got.out_count, got.halted);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  bfeu_in_if  in_ch ();
  bfeu_out_if out_ch ();

  brainfuck_execute_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  bfeu_scoreboard sb;
  bit             burst_mode;
  int unsigned    long_scans;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // idle length: mostly none or short, now and then long
  function automatic int unsigned gap_len();
    int unsigned r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // mostly small values so pointer and cells stay in a busy region
  function automatic logic signed [ARG_W-1:0] rand_arg();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return ARG_W'(int'($urandom_range(0, 16)) - 8);
    if (r < 85) return ARG_W'($urandom_range(1, 300));
    return ARG_W'($urandom);
  endfunction

  // one instruction beat, after an optional idle gap
  task automatic send_instr(logic [ACT_W-1:0] action, logic signed [ARG_W-1:0] arg,
                            logic [PC_W-1:0] pc, logic [BYTE_W-1:0] rbyte);
    int unsigned gap;
    gap = gap_len();
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
    @(negedge clk);
    in_ch.valid      = 1'b1;
    in_ch.action     = action;
    in_ch.argument   = arg;
    in_ch.current_pc = pc;
    in_ch.read_byte  = rbyte;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_instr(action, arg, pc, rbyte);
  endtask

  // hold off the sender until every owed result has come back
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.owed_results.size() != 0) @(posedge clk);
  endtask

  // corners: wraps, extreme arguments, non-positive counts, scans, halts
  task automatic run_directed();
    send_instr(ACT_PUT,       0,      0,    8'h00);
    send_instr(ACT_JZ,        4095,   4095, 8'h00);
    send_instr(ACT_JNZ,       5,      4095, 8'h00);
    send_instr(ACT_VAL_INC,   32767,  1,    8'hFF);
    send_instr(ACT_VAL_DEC,   -32768, 2,    8'h00);
    send_instr(ACT_PUT,       32767,  3,    8'h00);
    send_instr(ACT_PUT,       -1,     4,    8'h00);
    send_instr(ACT_JNZ,       -2,     5,    8'h00);
    send_instr(ACT_JZ,        100,    6,    8'h00);
    send_instr(ACT_PTR_INC,   -32768, 7,    8'h00);
    send_instr(ACT_PTR_DEC,   1,      8,    8'h00);
    send_instr(ACT_GET,       1,      9,    8'hA5);
    send_instr(ACT_GET,       0,      10,   8'hFF);
    send_instr(ACT_GET,       -32768, 11,   8'h5A);
    send_instr(ACT_SCAN,      1,      12,   8'h00);
    send_instr(ACT_PTR_DEC,   2,      13,   8'h00);
    send_instr(ACT_MOVEADD,   1,      14,   8'h00);
    send_instr(ACT_PTR_INC,   1,      15,   8'h00);
    send_instr(ACT_MOVEADD,   -32768, 16,   8'h00);
    send_instr(ACT_VAL_INC,   3,      17,   8'h00);
    // stride zero on a nonzero cell: full lap, pointer unchanged
    send_instr(ACT_SCAN,      0,      18,   8'h00);
    send_instr(ACT_ZERO,      0,      19,   8'h00);
    send_instr(ACT_SCAN,      0,      20,   8'h00);
    send_instr(ACT_MOVEADD,   7,      21,   8'h00);
    send_instr(ACT_END,       0,      4095, 8'h00);
    send_instr(ACT_UNUSED_HI, -1,     22,   8'hFF);
    send_instr(ACT_PTR_INC,   32767,  23,   8'h00);
  endtask

  task automatic run_random(int unsigned n);
    logic [ACT_W-1:0]        action;
    logic signed [ARG_W-1:0] arg;
    int unsigned             r;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 100 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      if (i % 250 == 249) drain();
      r = $urandom_range(0, 99);
      if (r < 3) action = ACT_END;
      else if (r < 6) action = ACT_W'(ACT_UNUSED_LO + $urandom_range(0, 3));
      else action = ACT_W'($urandom_range(ACT_PTR_INC, ACT_MOVEADD));
      arg = rand_arg();
      // keep full-lap scans rare so run time stays bounded
      if (action == ACT_SCAN && sb.scan_length(arg) > LONG_SCAN) begin
        if (long_scans >= MAX_LONG_SCANS) action = ACT_ZERO;
        else long_scans++;
      end
      send_instr(action, arg, PC_W'($urandom), BYTE_W'($urandom));
    end
    burst_mode = 1'b0;
  endtask

  // result side: random backpressure, check every accepted beat
  initial begin
    exec_result_t got;
    int unsigned  stall_left;
    out_ch.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (burst_mode || stall_left == 0) begin
        out_ch.ready = 1'b1;
        if (!burst_mode) stall_left = gap_len();
      end else begin
        out_ch.ready = 1'b0;
        stall_left--;
      end
      @(posedge clk);
      if (rst_n && out_ch.valid === 1'b1 && out_ch.ready) begin
        got.next_pc   = out_ch.next_pc;
        got.out_byte  = out_ch.out_byte;
        got.out_count = out_ch.out_count;
        got.halted    = out_ch.halted;
        sb.check_result(got);
      end
    end
  end

  // main sequence
  initial begin
    sb               = new();
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.action     = ACT_END;
    in_ch.argument   = '0;
    in_ch.current_pc = '0;
    in_ch.read_byte  = '0;
    burst_mode       = 1'b0;
    long_scans       = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    run_directed();
    drain();
    run_random(N_RANDOM);

    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.owed_results.size() != 0) @(posedge clk);
    // watch for stray result beats
    repeat (64) @(posedge clk);

    $display("Ran %0d instructions through the tape unit, %0d results checked.",
             sb.executed, sb.checked);
    $display("Halts seen: %0d, long random scans: %0d, errors: %0d.",
             sb.halts, long_scans, sb.errors);
    if (sb.errors == 0 && sb.owed_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/bfeu_pkg.sv
rtl/core/bfeu_if.sv
rtl/core/bfeu_ram.sv
rtl/core/bfeu_queue.sv
rtl/core/bfeu_front.sv
rtl/core/bfeu_back.sv
rtl/core/brainfuck_execute_unit.sv
tb/tb_top.sv
